// ===== hdl/febwt_pkg.sv =====
// ----------------------------------------------------------------------------
// Erase-before-write tracker package
// Field widths, default sizes and command and status codes shared by the
// tracker and its channel interfaces.
// ----------------------------------------------------------------------------
package febwt_pkg;

   localparam int CHANNELS_DEF = 4;
   localparam int LUNS_DEF     = 4;
   localparam int BLOCKS_DEF   = 64;
   localparam int PAGES_DEF    = 16;

   localparam int CHANNEL_W = 2;
   localparam int LUN_W     = 2;
   localparam int BLOCK_W   = 6;
   localparam int PAGE_W    = 4;

   typedef enum logic [1:0] {
      CMD_READ  = 2'd0,
      CMD_ERASE = 2'd1,
      CMD_WRITE = 2'd2,
      CMD_NONE  = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_BAD_SPAN   = 2'd1,
      ST_DIRTY_PAGE = 2'd2
   } status_type;

   typedef enum logic {
      FUNC_READ  = 1'b0,
      FUNC_WRITE = 1'b1
   } func_type;

endpackage

// ===== hdl/febwt_if.sv =====
// ----------------------------------------------------------------------------
// Erase-before-write tracker channels
// Request and response channels with valid/ready handshake; one beat moves
// one request or one flash command.
// ----------------------------------------------------------------------------
interface febwt_req_if import febwt_pkg::*; ();
   logic                 valid;
   logic                 ready;
   func_type             func;
   logic [CHANNEL_W-1:0] channel;
   logic [LUN_W-1:0]     lun;
   logic [BLOCK_W-1:0]   block;
   logic [PAGE_W-1:0]    first_page;
   logic [PAGE_W-1:0]    last_page;

   modport source (output valid, func, channel, lun, block, first_page, last_page,
                   input ready);
   modport sink (input valid, func, channel, lun, block, first_page, last_page,
                 output ready);
endinterface

interface febwt_rsp_if import febwt_pkg::*; ();
   logic                 valid;
   logic                 ready;
   command_type          command;
   logic [CHANNEL_W-1:0] out_channel;
   logic [LUN_W-1:0]     out_lun;
   logic [BLOCK_W-1:0]   out_block;
   logic [PAGE_W-1:0]    out_page;
   status_type           status;
   logic                 last;

   modport source (output valid, command, out_channel, out_lun, out_block, out_page,
                   status, last, input ready);
   modport sink (input valid, command, out_channel, out_lun, out_block, out_page,
                 status, last, output ready);
endinterface

// ===== hdl/febwt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module febwt_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 1024
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/flash_erase_before_write_tracker.sv =====
// ----------------------------------------------------------------------------
// Flash erase-before-write tracker
// A bad span answers with a single ST_BAD_SPAN response; other requests read
// the state RAM first. Span commands then go out one per cycle while rsp accepts
// them, and each keep scan visits all PAGES pages. Only one request is taken at a
// time. After reset all CHANNELS*LUNS*BLOCKS entries (1024 by default) of the
// state RAM are cleared with req not ready.
// ----------------------------------------------------------------------------
module flash_erase_before_write_tracker import febwt_pkg::*; #(
   parameter int CHANNELS = CHANNELS_DEF,
   parameter int LUNS     = LUNS_DEF,
   parameter int BLOCKS   = BLOCKS_DEF,
   parameter int PAGES    = PAGES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   febwt_req_if.sink  req,
   febwt_rsp_if.source rsp
);

   localparam int DEPTH = CHANNELS * LUNS * BLOCKS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW    = $clog2(PAGES);
   localparam int WW    = PAGES + 1;

   typedef enum logic [9:0] {
      S_CLEAR   = 10'b0000000001,
      S_IDLE    = 10'b0000000010,
      S_LOOKUP  = 10'b0000000100,
      S_LOAD    = 10'b0000001000,
      S_KEEP_RD = 10'b0000010000,
      S_ERASE   = 10'b0000100000,
      S_KEEP_WR = 10'b0001000000,
      S_SPAN    = 10'b0010000000,
      S_STORE   = 10'b0100000000,
      S_BAD     = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;

   func_type             func_ff, func_in;
   logic [CHANNEL_W-1:0] ch_ff, ch_in;
   logic [LUN_W-1:0]     lun_ff, lun_in;
   logic [BLOCK_W-1:0]   blk_ff, blk_in;
   logic [PAGE_W-1:0]    fp_ff, fp_in;
   logic [PAGE_W-1:0]    lp_ff, lp_in;
   logic [AW-1:0]        addr_ff, addr_in;
   logic [PAGES-1:0]     span_ff, span_in;
   logic [PAGES-1:0]     eff_ff, eff_in;
   logic [PAGES-1:0]     keep_ff, keep_in;
   logic [PW-1:0]        page_ff, page_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   command_type          cmd_ff, cmd_in;
   logic [CHANNEL_W-1:0] och_ff, och_in;
   logic [LUN_W-1:0]     olun_ff, olun_in;
   logic [BLOCK_W-1:0]   oblk_ff, oblk_in;
   logic [PAGE_W-1:0]    opage_ff, opage_in;
   status_type           status_ff, status_in;
   logic                 last_ff, last_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [WW-1:0] wr_data;
   logic          rd_en;
   logic [WW-1:0] rd_data;

   logic             bad_span;
   logic [PAGES-1:0] span_req;
   logic [PAGES-1:0] pdb;
   logic             need_erase;
   logic             emit_ok;
   logic             emit;
   logic             page_end;
   logic             span_end;

   febwt_ram #(
      .WIDTH (WW),
      .DEPTH (DEPTH)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign bad_span = (32'(req.channel) >= 32'(CHANNELS)) || (32'(req.lun) >= 32'(LUNS)) ||
                     (32'(req.block) >= 32'(BLOCKS)) || (req.first_page > req.last_page) ||
                     (32'(req.last_page) >= 32'(PAGES));

   always_comb begin
      for (int p = 0; p < PAGES; p++) begin
         span_req[p] = (32'(p) >= 32'(req.first_page)) && (32'(p) <= 32'(req.last_page));
      end
   end

   assign pdb        = rd_data[PAGES-1:0];
   assign need_erase = rd_data[PAGES] && (|(pdb & span_ff));
   assign emit_ok    = !rsp_valid_ff || rsp.ready;
   assign page_end   = (page_ff == PW'(PAGES - 1));
   assign span_end   = (32'(page_ff) == 32'(lp_ff));
   assign req.ready  = (state_ff == S_IDLE);

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      func_in   = func_ff;
      ch_in     = ch_ff;
      lun_in    = lun_ff;
      blk_in    = blk_ff;
      fp_in     = fp_ff;
      lp_in     = lp_ff;
      addr_in   = addr_ff;
      span_in   = span_ff;
      eff_in    = eff_ff;
      keep_in   = keep_ff;
      page_in   = page_ff;
      emit      = 1'b0;
      cmd_in    = cmd_ff;
      och_in    = och_ff;
      olun_in   = olun_ff;
      oblk_in   = oblk_ff;
      opage_in  = opage_ff;
      status_in = status_ff;
      last_in   = last_ff;
      wr_en     = 1'b0;
      wr_addr   = addr_ff;
      wr_data   = '0;
      rd_en     = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req.valid) begin
               func_in  = req.func;
               ch_in    = req.channel;
               lun_in   = req.lun;
               blk_in   = req.block;
               fp_in    = req.first_page;
               lp_in    = req.last_page;
               span_in  = span_req;
               addr_in  = AW'(32'(req.channel) + 32'(req.lun) * CHANNELS +
                              32'(req.block) * (CHANNELS * LUNS));
               state_in = bad_span ? S_BAD : S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            rd_en    = 1'b1;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            keep_in = pdb & ~span_ff;
            if ((func_ff == FUNC_WRITE) && need_erase) begin
               eff_in   = pdb & ~span_ff;
               page_in  = '0;
               state_in = S_KEEP_RD;
            end else begin
               eff_in   = pdb;
               page_in  = PW'(fp_ff);
               state_in = S_SPAN;
            end
         end
         S_KEEP_RD, S_KEEP_WR: begin
            if (!keep_ff[page_ff] || emit_ok) begin
               if (keep_ff[page_ff]) begin
                  emit      = 1'b1;
                  cmd_in    = (state_ff == S_KEEP_RD) ? CMD_READ : CMD_WRITE;
                  opage_in  = PAGE_W'(page_ff);
                  status_in = ST_OK;
                  last_in   = 1'b0;
               end
               if (page_end) begin
                  if (state_ff == S_KEEP_RD) begin
                     state_in = S_ERASE;
                  end else begin
                     page_in  = PW'(fp_ff);
                     state_in = S_SPAN;
                  end
               end else begin
                  page_in = page_ff + PW'(1);
               end
            end
         end
         S_ERASE: begin
            if (emit_ok) begin
               emit      = 1'b1;
               cmd_in    = CMD_ERASE;
               opage_in  = '0;
               status_in = ST_OK;
               last_in   = 1'b0;
               page_in   = '0;
               state_in  = S_KEEP_WR;
            end
         end
         S_SPAN: begin
            if (emit_ok) begin
               emit      = 1'b1;
               opage_in  = PAGE_W'(page_ff);
               last_in   = span_end;
               status_in = ST_OK;
               if (func_ff == FUNC_READ) begin
                  cmd_in = CMD_READ;
               end else if (eff_ff[page_ff]) begin
                  cmd_in    = CMD_NONE;
                  status_in = ST_DIRTY_PAGE;
               end else begin
                  cmd_in = CMD_WRITE;
               end
               if (span_end) begin
                  state_in = (func_ff == FUNC_WRITE) ? S_STORE : S_IDLE;
               end else begin
                  page_in = page_ff + PW'(1);
               end
            end
         end
         S_STORE: begin
            wr_en    = 1'b1;
            wr_data  = {(|(~eff_ff & span_ff)), (eff_ff | span_ff)};
            state_in = S_IDLE;
         end
         S_BAD: begin
            if (emit_ok) begin
               emit      = 1'b1;
               cmd_in    = CMD_NONE;
               opage_in  = fp_ff;
               status_in = ST_BAD_SPAN;
               last_in   = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
         och_in       = ch_ff;
         olun_in      = lun_ff;
         oblk_in      = blk_ff;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      ch_ff     <= ch_in;
      lun_ff    <= lun_in;
      blk_ff    <= blk_in;
      fp_ff     <= fp_in;
      lp_ff     <= lp_in;
      addr_ff   <= addr_in;
      span_ff   <= span_in;
      eff_ff    <= eff_in;
      keep_ff   <= keep_in;
      page_ff   <= page_in;
      cmd_ff    <= cmd_in;
      och_ff    <= och_in;
      olun_ff   <= olun_in;
      oblk_ff   <= oblk_in;
      opage_ff  <= opage_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.command     = cmd_ff;
   assign rsp.out_channel = och_ff;
   assign rsp.out_lun     = olun_ff;
   assign rsp.out_block   = oblk_ff;
   assign rsp.out_page    = opage_ff;
   assign rsp.status      = status_ff;
   assign rsp.last        = last_ff;

endmodule
